// ===== rtl/move_to_front_encoder_macros.svh =====
// assertion macros shared by the encoder files
`ifndef MOVE_TO_FRONT_ENCODER_MACROS_SVH
`define MOVE_TO_FRONT_ENCODER_MACROS_SVH

`ifndef ASSERT_OFF

// property checked on every clock edge outside reset
`define MTF_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("mtf assertion failed");

// condition that must never be seen outside reset
`define MTF_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("mtf forbidden condition seen");

`else

`define MTF_ASSERT(label, clk, rstn, prop)
`define MTF_NEVER(label, clk, rstn, cond)

`endif

`endif

// ===== rtl/mtf_pkg.sv =====
`timescale 1ns / 1ps

package mtf_pkg;

    localparam int SYMBOL_W = 8;

    // input beat
    typedef struct packed {
        logic [SYMBOL_W-1:0] symbol;
        logic                block_end;
    } mtf_in_t;

    // result beat
    typedef struct packed {
        logic [SYMBOL_W-1:0] rank;
        logic                rank_last;
    } mtf_out_t;

    // token that travels down the cell chain, one cell per cycle while the chain advances
    typedef struct packed {
        logic                valid;
        logic                searching;
        logic                hit;
        logic                last;
        logic [SYMBOL_W-1:0] symbol;
        logic [SYMBOL_W-1:0] carry;
        logic [SYMBOL_W-1:0] rank;
    } mtf_token_t;

endpackage

// ===== rtl/mtf_cell.sv =====
`timescale 1ns / 1ps
`include "move_to_front_encoder_macros.svh"

module mtf_cell #(
    parameter int IDX = 0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  mtf_pkg::mtf_token_t in_tok,
    output mtf_pkg::mtf_token_t out_tok
);
    import mtf_pkg::*;

    localparam logic [SYMBOL_W-1:0] IDX_VAL = SYMBOL_W'(IDX);

    logic [SYMBOL_W-1:0] value_reg;
    logic [SYMBOL_W-1:0] value_next;
    mtf_token_t          tok_reg;
    mtf_token_t          tok_next;
    logic                entry_match;
    logic                tok_live;
    logic                hit_here;
    logic                pass_through;

    assign entry_match  = value_reg == in_tok.symbol;
    assign tok_live     = advance && in_tok.valid;
    assign hit_here     = tok_live && in_tok.searching && entry_match;
    assign pass_through = tok_live && !in_tok.searching && !in_tok.last;

    // compare, take the carried entry, hand the old entry onward
    always_comb begin
        tok_next   = in_tok;
        value_next = value_reg;
        if (in_tok.valid) begin
            if (in_tok.searching) begin
                value_next = in_tok.carry;
                if (entry_match) begin
                    tok_next.searching = 1'b0;
                    tok_next.hit       = 1'b1;
                    tok_next.rank      = IDX_VAL;
                end else begin
                    tok_next.carry = value_reg;
                end
            end
            // end of block puts this entry back to identity
            if (in_tok.last) begin
                value_next = IDX_VAL;
            end
        end
    end

    // cell entry and outgoing token
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= IDX_VAL;
            tok_reg   <= '0;
        end else if (advance) begin
            value_reg <= value_next;
            tok_reg   <= tok_next;
        end
    end

    assign out_tok = tok_reg;

    `MTF_ASSERT(a_cell_hit_rank, aclk, aresetn, hit_here |=> tok_reg.hit && tok_reg.rank == IDX_VAL)
    `MTF_ASSERT(a_cell_block_reset, aclk, aresetn, tok_live && in_tok.last |=> value_reg == IDX_VAL)
    `MTF_ASSERT(a_cell_keep_after_hit, aclk, aresetn, pass_through |=> value_reg == $past(value_reg))

endmodule

// ===== rtl/move_to_front_encoder.sv =====
`timescale 1ns / 1ps
`include "move_to_front_encoder_macros.svh"

// Move-to-front encoder: each input beat carries a byte symbol and a block_end
// flag; each result beat carries the symbol's rank in the recency list before
// the move and a copy of the flag. The list is a chain of ALPHABET_SIZE cells,
// one entry per cell, and every symbol walks the chain one cell per cycle while
// the chain advances, so one beat is taken per cycle unless the result side
// stalls; each beat passes through the cell registers and then the output
// register, and results leave in input order. The list starts as identity and
// returns to identity after a block_end beat. A symbol at or above
// ALPHABET_SIZE gets rank 0 and leaves the list alone. A stall on the result
// side holds the whole chain and the input side.
module move_to_front_encoder #(
    parameter int ALPHABET_SIZE = 256
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mtf_pkg::mtf_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output mtf_pkg::mtf_out_t m_data
);
    import mtf_pkg::*;

    localparam int ALPHA_W = SYMBOL_W + 1;

    mtf_token_t tok [ALPHABET_SIZE+1];
    mtf_token_t head_tok;
    mtf_token_t tail_tok;
    logic       advance;
    logic       in_range;
    logic       m_valid_reg;
    mtf_out_t   m_data_reg;

    // chain moves when the output register is free or being drained
    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;

    assign in_range = {1'b0, s_data.symbol} < ALPHA_W'(ALPHABET_SIZE);

    // token entering the first cell
    always_comb begin
        head_tok           = '0;
        head_tok.valid     = s_valid && advance;
        head_tok.searching = in_range;
        head_tok.last      = s_data.block_end;
        head_tok.symbol    = s_data.symbol;
        head_tok.carry     = s_data.symbol;
    end

    assign tok[0]   = head_tok;
    assign tail_tok = tok[ALPHABET_SIZE];

    // row of list cells
    for (genvar i = 0; i < ALPHABET_SIZE; i++) begin : g_cell
        mtf_cell #(
            .IDX(i)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .advance (advance),
            .in_tok  (tok[i]),
            .out_tok (tok[i+1])
        );
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= tail_tok.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg.rank      <= tail_tok.hit ? tail_tok.rank : '0;
            m_data_reg.rank_last <= tail_tok.last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `MTF_NEVER(a_tail_unmatched, aclk, aresetn, tail_tok.valid && tail_tok.searching)
    `MTF_ASSERT(a_accept_enters_chain, aclk, aresetn, s_valid && s_ready |=> tok[1].valid)
    `MTF_ASSERT(a_stall_holds_tail, aclk, aresetn, !advance |=> tail_tok.valid == $past(tail_tok.valid))

endmodule
